// File: rtl/hbbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbl_pkg
// Shared types and constants of the handshaked bit-banged byte link.
// ----------------------------------------------------------------------------
package hbbl_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int TDATA_W  = 16;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 20;
    localparam int TICK_W   = 20;
    localparam int PERIOD_W = 16;
    localparam int LIMIT_W  = 8;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PRE_LIMIT  = 2'd2;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd100;
    localparam logic [TICK_W-1:0]   TIMEOUT_RST    = 20'd10000;
    localparam logic [LIMIT_W-1:0]  PRE_LIMIT_RST  = 8'd16;

    // request codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // completion status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_PREREADS = 3'd3;
    localparam logic [2:0] ST_NOTHING  = 3'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b0000000001,
        PH_W_CHECK = 10'b0000000010,
        PH_W_ACK   = 10'b0000000100,
        PH_W_BITS  = 10'b0000001000,
        PH_W_HIGH  = 10'b0000010000,
        PH_W_END   = 10'b0000100000,
        PH_R_LOW   = 10'b0001000000,
        PH_R_BITS  = 10'b0010000000,
        PH_R_TAIL  = 10'b0100000000,
        PH_R_HIGH  = 10'b1000000000
    } phase_t;

endpackage

// File: rtl/handshake_bitbang_byte_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handshake_bitbang_byte_link
// Two-wire handshaked byte link engine, one tick request per line sample.
// ----------------------------------------------------------------------------
// Timing: an accepted request sits in the input register, then its result is
// loaded into the result register once that is free or being read; the ring
// head byte is prefetched into a register. Throughput: one request per cycle
// while the result output is not stalled, one result per request.
// Reset: asynchronous, active low; control registers return to their defaults, the
// engine goes idle with the line high and the ring empty. Ring contents are
// not cleared and need no clearing pass.
module handshake_bitbang_byte_link #(
    parameter int RING_DEPTH = hbbl_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] command, [9:2] tx_byte, [10] line_in, [15:11] zero
    input  logic [hbbl_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] line_out, [1] busy_res, [2] done_res, [5:3] status,
    // [13:6] rx_data, [14] rx_valid, [15] available
    output logic [hbbl_pkg::TDATA_W-1:0]  m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [hbbl_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [hbbl_pkg::CFG_DW-1:0]   cfg_wdata
);
    import hbbl_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] RING_LAST = AW'(RING_DEPTH - 1);

    // configuration
    logic [PERIOD_W-1:0] bit_period_reg;
    logic [TICK_W-1:0]   timeout_reg;
    logic [LIMIT_W-1:0]  pre_limit_reg;

    // handshake stages
    logic                in_valid_reg;
    logic [TDATA_W-1:0]  in_data_reg;
    logic                out_valid_reg;
    logic [TDATA_W-1:0]  out_data_reg;
    logic                adv;

    // engine state
    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [3:0]          bit_idx_reg, bit_idx_next;
    logic [7:0]          shift_reg, shift_next;
    logic [7:0]          rx_acc_reg, rx_acc_next;
    logic [LIMIT_W-1:0]  pre_cnt_reg, pre_cnt_next;
    logic                pend_wr_reg, pend_wr_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic                drive_reg, drive_next;

    // ring memory and prefetched head byte
    logic [7:0]          ring_mem [RING_DEPTH];
    logic [7:0]          head_data_reg;
    logic [AW-1:0]       head_addr;
    logic                mem_we;

    // per-step values
    logic [1:0]          cmd;
    logic [7:0]          txb;
    logic                line;
    logic                done;
    logic [2:0]          st;
    logic [7:0]          rxd;
    logic                rxv;
    logic [AW-1:0]       tail_inc;
    logic [TICK_W-1:0]   tick_dec;
    logic [TICK_W-1:0]   period_ext;
    logic [TDATA_W-1:0]  result;

    assign cmd  = in_data_reg[1:0];
    assign txb  = in_data_reg[9:2];
    assign line = in_data_reg[10];

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign period_ext = {{(TICK_W-PERIOD_W){1'b0}}, bit_period_reg};
    assign tick_dec   = (tick_reg > '0) ? tick_reg - 1'b1 : '0;
    assign tail_inc   = (tail_reg == RING_LAST) ? '0 : tail_reg + 1'b1;
    assign head_addr  = adv ? head_next : head_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        rx_acc_next  = rx_acc_reg;
        pre_cnt_next = pre_cnt_reg;
        pend_wr_next = pend_wr_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        drive_next   = drive_reg;
        done         = 1'b0;
        st           = ST_OK;
        rxd          = '0;
        rxv          = 1'b0;
        mem_we       = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd == CMD_WRITE)
            begin
                shift_next   = txb;
                pend_wr_next = 1'b1;
                pre_cnt_next = '0;
                phase_next   = PH_W_CHECK;
            end
            else if (cmd == CMD_READ)
            begin
                pend_wr_next = 1'b0;
                if (head_reg != tail_reg)
                begin
                    rxd       = head_data_reg;
                    rxv       = 1'b1;
                    head_next = (head_reg == RING_LAST) ? '0 : head_reg + 1'b1;
                    done      = 1'b1;
                end
                else
                begin
                    tick_next  = '0;
                    phase_next = PH_R_LOW;
                end
            end
        end

        case (phase_next)
            PH_W_CHECK:
            begin
                drive_next = 1'b0;
                if (!line)
                begin
                    // remote is already sending: absorb its byte first
                    rx_acc_next  = '0;
                    bit_idx_next = '0;
                    tick_next    = {5'd0, bit_period_reg[PERIOD_W-1:1]};
                    phase_next   = PH_R_BITS;
                end
                else
                begin
                    tick_next  = '0;
                    phase_next = PH_W_ACK;
                end
            end
            PH_W_ACK:
            begin
                if (!line)
                begin
                    bit_idx_next = '0;
                    drive_next   = shift_reg[0];
                    tick_next    = period_ext;
                    phase_next   = PH_W_BITS;
                end
                else if (tick_next >= timeout_reg)
                begin
                    done = 1'b1;
                    st   = ST_TIMEOUT;
                end
                else
                begin
                    tick_next = tick_next + 1'b1;
                end
            end
            PH_W_BITS:
            begin
                tick_next = tick_dec;
                if (tick_dec == '0)
                begin
                    bit_idx_next = bit_idx_reg + 1'b1;
                    if (bit_idx_next >= BITS_PER_BYTE)
                    begin
                        phase_next = PH_W_HIGH;
                    end
                    else
                    begin
                        drive_next = shift_reg[bit_idx_next[2:0]];
                        tick_next  = period_ext;
                    end
                end
            end
            PH_W_HIGH:
            begin
                if (line)
                begin
                    drive_next = 1'b1;
                    tick_next  = (period_ext << 2) + period_ext;
                    phase_next = PH_W_END;
                end
                else if (tick_reg >= timeout_reg)
                begin
                    done = 1'b1;
                    st   = ST_TIMEOUT;
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            PH_W_END:
            begin
                tick_next = tick_dec;
                if (tick_dec == '0)
                begin
                    done = 1'b1;
                end
            end
            PH_R_LOW:
            begin
                if (!line)
                begin
                    drive_next   = 1'b0;
                    rx_acc_next  = '0;
                    bit_idx_next = '0;
                    tick_next    = {5'd0, bit_period_reg[PERIOD_W-1:1]};
                    phase_next   = PH_R_BITS;
                end
                else if (tick_next >= timeout_reg)
                begin
                    done = 1'b1;
                    st   = ST_NOTHING;
                end
                else
                begin
                    tick_next = tick_next + 1'b1;
                end
            end
            PH_R_BITS:
            begin
                tick_next = tick_dec;
                if (tick_dec == '0)
                begin
                    rx_acc_next[bit_idx_reg[2:0]] = line;
                    bit_idx_next = bit_idx_reg + 1'b1;
                    tick_next    = period_ext;
                    if (bit_idx_next >= BITS_PER_BYTE)
                    begin
                        phase_next = PH_R_TAIL;
                    end
                end
            end
            PH_R_TAIL:
            begin
                tick_next = tick_dec;
                if (tick_dec == '0)
                begin
                    drive_next = 1'b1;
                    phase_next = PH_R_HIGH;
                end
            end
            PH_R_HIGH:
            begin
                if (line)
                begin
                    if (tail_inc == head_reg)
                    begin
                        done = 1'b1;
                        st   = ST_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        tail_next = tail_inc;
                        if (pend_wr_reg)
                        begin
                            pre_cnt_next = pre_cnt_reg + 1'b1;
                            if (pre_cnt_next >= pre_limit_reg)
                            begin
                                done = 1'b1;
                                st   = ST_PREREADS;
                            end
                            else
                            begin
                                tick_next  = '0;
                                phase_next = PH_W_CHECK;
                            end
                        end
                        else
                        begin
                            // on an empty ring the new byte is the head byte
                            rxd       = (head_reg == tail_reg) ? rx_acc_reg : head_data_reg;
                            rxv       = 1'b1;
                            head_next = (head_reg == RING_LAST) ? '0 : head_reg + 1'b1;
                            done      = 1'b1;
                        end
                    end
                end
                else if (tick_reg >= timeout_reg)
                begin
                    done = 1'b1;
                    st   = ST_TIMEOUT;
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (done)
        begin
            if (st != ST_OK)
            begin
                drive_next = 1'b1;
            end
            phase_next   = PH_IDLE;
            pend_wr_next = 1'b0;
            tick_next    = '0;
        end

        result = {(head_next != tail_next) || !line, rxv, rxd, st, done,
                  phase_next != PH_IDLE, drive_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RST;
            timeout_reg    <= TIMEOUT_RST;
            pre_limit_reg  <= PRE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BIT_PERIOD: bit_period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_wdata[TICK_W-1:0];
                CFG_PRE_LIMIT:  pre_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (adv)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            rx_acc_reg  <= '0;
            pre_cnt_reg <= '0;
            pend_wr_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            drive_reg   <= 1'b1;
        end
        else if (adv)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            rx_acc_reg  <= rx_acc_next;
            pre_cnt_reg <= pre_cnt_next;
            pend_wr_reg <= pend_wr_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            drive_reg   <= drive_next;
        end
    end

    // ring write at tail; keep head byte prefetched, bypass a write to it
    always_ff @(posedge clk)
    begin
        if (adv && mem_we)
        begin
            ring_mem[tail_reg] <= rx_acc_reg;
        end
        if (adv && mem_we && (tail_reg == head_addr))
        begin
            head_data_reg <= rx_acc_reg;
        end
        else
        begin
            head_data_reg <= ring_mem[head_addr];
        end
    end

endmodule

// File: rtl/hbbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbl_checker
// Port-level checks of the byte link results, bound to the top level.
// ----------------------------------------------------------------------------
module hbbl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [hbbl_pkg::TDATA_W-1:0] m_axis_tdata
);
    import hbbl_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a returned byte only comes with a successful completion
    a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[14] |->
            m_axis_tdata[2] && !m_axis_tdata[1] && (m_axis_tdata[5:3] == ST_OK))
        else $error("rx byte without successful completion");

    // status is zero unless the request finished
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> (m_axis_tdata[5:3] == ST_OK))
        else $error("status set without completion");

    // a failure releases the line
    a_fail_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] && (m_axis_tdata[5:3] != ST_OK) |->
            m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("line not released after failure");

endmodule

bind handshake_bitbang_byte_link hbbl_checker u_hbbl_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the handshaked bit-banged byte link. A reactive
// remote peer drives the sampled line tick by tick, following the engine's
// predicted phase; every status word is checked against a tick-level model.
// ----------------------------------------------------------------------------
module tb_top;
    import hbbl_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic       line_out;
        logic       busy;
        logic       done;
        logic [2:0] status;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       available;
    } link_reply_t;

    class link_tracker;
        bit [15:0]   cfg_period;
        bit [19:0]   cfg_timeout;
        bit [7:0]    cfg_limit;
        phase_t      phase;
        bit [19:0]   tick_cnt;
        bit [3:0]    bit_idx;
        bit [7:0]    shreg;
        bit [7:0]    pre_cnt;
        bit [7:0]    rx_acc;
        bit          pend_wr;
        bit          drive;
        bit [7:0]    ring [RING_DEPTH_DEF];
        int          head;
        int          tail;
        link_reply_t awaited[$];
        int          errors;
        int          shown;
        int          replies;

        function new();
            cfg_period  = BIT_PERIOD_RST;
            cfg_timeout = TIMEOUT_RST;
            cfg_limit   = PRE_LIMIT_RST;
            phase       = PH_IDLE;
            drive       = 1'b1;
        endfunction

        // 1 level seen, -1 timed out, 0 keep waiting
        function int watch_line(bit line, bit level);
            if (line == level)
                return 1;
            if (tick_cnt >= cfg_timeout)
                return -1;
            tick_cnt++;
            return 0;
        endfunction

        function void open_receive();
            drive    = 1'b0;
            rx_acc   = 8'h00;
            bit_idx  = 4'd0;
            tick_cnt = 20'(cfg_period >> 1);
            phase    = PH_R_BITS;
        endfunction

        // phase the tick logic runs in once cmd is applied
        function phase_t phase_for(bit [1:0] cmd);
            if (phase != PH_IDLE)
                return phase;
            if (cmd == CMD_WRITE)
                return PH_W_CHECK;
            if (cmd == CMD_READ && head == tail)
                return PH_R_LOW;
            return PH_IDLE;
        endfunction

        function void take_request(bit [1:0] cmd, bit [7:0] txb, bit line);
            link_reply_t r;
            bit          done;
            bit [2:0]    st;
            bit [7:0]    rxd;
            bit          rxv;
            int          w;
            int          nt;
            done = 1'b0;
            st   = ST_OK;
            rxd  = 8'h00;
            rxv  = 1'b0;
            if (phase == PH_IDLE)
            begin
                if (cmd == CMD_WRITE)
                begin
                    shreg   = txb;
                    pend_wr = 1'b1;
                    pre_cnt = 8'd0;
                    phase   = PH_W_CHECK;
                end
                else if (cmd == CMD_READ)
                begin
                    pend_wr = 1'b0;
                    if (head != tail)
                    begin
                        rxd  = ring[head];
                        rxv  = 1'b1;
                        head = (head + 1) % RING_DEPTH_DEF;
                        done = 1'b1;
                    end
                    else
                    begin
                        tick_cnt = 20'd0;
                        phase    = PH_R_LOW;
                    end
                end
            end

            case (phase)
                PH_W_CHECK:
                begin
                    // remote already talking: absorb its byte first
                    if (!line)
                        open_receive();
                    else
                    begin
                        drive    = 1'b0;
                        tick_cnt = 20'd0;
                        phase    = PH_W_ACK;
                    end
                end
                PH_W_ACK:
                begin
                    w = watch_line(line, 1'b0);
                    if (w < 0)
                    begin
                        done = 1'b1;
                        st   = ST_TIMEOUT;
                    end
                    else if (w > 0)
                    begin
                        bit_idx  = 4'd0;
                        drive    = shreg[0];
                        tick_cnt = 20'(cfg_period);
                        phase    = PH_W_BITS;
                    end
                end
                PH_W_BITS:
                begin
                    if (tick_cnt > 0)
                        tick_cnt--;
                    if (tick_cnt == 0)
                    begin
                        bit_idx++;
                        if (bit_idx >= BITS_PER_BYTE)
                            phase = PH_W_HIGH;
                        else
                        begin
                            drive    = shreg[bit_idx];
                            tick_cnt = 20'(cfg_period);
                        end
                    end
                end
                PH_W_HIGH:
                begin
                    w = watch_line(line, 1'b1);
                    if (w < 0)
                    begin
                        done = 1'b1;
                        st   = ST_TIMEOUT;
                    end
                    else if (w > 0)
                    begin
                        drive    = 1'b1;
                        tick_cnt = 20'(5 * int'(cfg_period));
                        phase    = PH_W_END;
                    end
                end
                PH_W_END:
                begin
                    if (tick_cnt > 0)
                        tick_cnt--;
                    if (tick_cnt == 0)
                        done = 1'b1;
                end
                PH_R_LOW:
                begin
                    w = watch_line(line, 1'b0);
                    if (w < 0)
                    begin
                        done = 1'b1;
                        st   = ST_NOTHING;
                    end
                    else if (w > 0)
                        open_receive();
                end
                PH_R_BITS:
                begin
                    if (tick_cnt > 0)
                        tick_cnt--;
                    if (tick_cnt == 0)
                    begin
                        rx_acc   = rx_acc | (8'(line) << bit_idx);
                        bit_idx++;
                        tick_cnt = 20'(cfg_period);
                        if (bit_idx >= BITS_PER_BYTE)
                            phase = PH_R_TAIL;
                    end
                end
                PH_R_TAIL:
                begin
                    if (tick_cnt > 0)
                        tick_cnt--;
                    if (tick_cnt == 0)
                    begin
                        drive = 1'b1;
                        phase = PH_R_HIGH;
                    end
                end
                PH_R_HIGH:
                begin
                    w = watch_line(line, 1'b1);
                    if (w < 0)
                    begin
                        done = 1'b1;
                        st   = ST_TIMEOUT;
                    end
                    else if (w > 0)
                    begin
                        nt = (tail + 1) % RING_DEPTH_DEF;
                        // one slot stays free to tell full from empty
                        if (nt == head)
                        begin
                            done = 1'b1;
                            st   = ST_FULL;
                        end
                        else
                        begin
                            ring[tail] = rx_acc;
                            tail       = nt;
                            if (pend_wr)
                            begin
                                pre_cnt++;
                                if (pre_cnt >= cfg_limit)
                                begin
                                    done = 1'b1;
                                    st   = ST_PREREADS;
                                end
                                else
                                begin
                                    tick_cnt = 20'd0;
                                    phase    = PH_W_CHECK;
                                end
                            end
                            else
                            begin
                                rxd  = ring[head];
                                rxv  = 1'b1;
                                head = (head + 1) % RING_DEPTH_DEF;
                                done = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (done)
            begin
                if (st != ST_OK)
                    drive = 1'b1;
                phase    = PH_IDLE;
                pend_wr  = 1'b0;
                tick_cnt = 20'd0;
            end

            r.line_out  = drive;
            r.busy      = (phase != PH_IDLE);
            r.done      = done;
            r.status    = st;
            r.rx_data   = rxd;
            r.rx_valid  = rxv;
            r.available = (head != tail) || !line;
            awaited.push_back(r);
        endfunction

        function void check_reply(logic [15:0] word);
            link_reply_t got;
            link_reply_t want;
            got.line_out  = word[0];
            got.busy      = word[1];
            got.done      = word[2];
            got.status    = word[5:3];
            got.rx_data   = word[13:6];
            got.rx_valid  = word[14];
            got.available = word[15];
            replies++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("reply %0d arrived with nothing awaited: %h", replies, word);
                end
                return;
            end
            want = awaited.pop_front();
            if (got.line_out !== want.line_out || got.busy !== want.busy ||
                got.done !== want.done || got.status !== want.status ||
                got.rx_data !== want.rx_data || got.rx_valid !== want.rx_valid ||
                got.available !== want.available)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("reply %0d: exp line=%0b busy=%0b done=%0b st=%0d rx=%h/%0b av=%0b",
                             replies, want.line_out, want.busy, want.done, want.status,
                             want.rx_data, want.rx_valid, want.available);
                    $display("    got line=%0b busy=%0b done=%0b st=%0d rx=%h/%0b av=%0b",
                             got.line_out, got.busy, got.done, got.status,
                             got.rx_data, got.rx_valid, got.available);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;

    link_tracker lnk;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          chatty_pct;
    bit          mute_forced;
    bit          peer_mute;
    bit [7:0]    peer_byte;
    int          cycle_count = 0;

    handshake_bitbang_byte_link dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            lnk.check_reply(m_axis_tdata);
    end

    // remote peer: line level it drives for a tick run in phase ph
    function automatic bit remote_level(phase_t ph);
        case (ph)
            PH_IDLE:    return ($urandom_range(0, 99) >= 10);
            PH_W_CHECK: return ($urandom_range(0, 99) >= chatty_pct);
            PH_W_ACK,
            PH_R_LOW:   return peer_mute || ($urandom_range(0, 2) != 0);
            PH_W_HIGH,
            PH_R_HIGH:  return !peer_mute && ($urandom_range(0, 2) == 0);
            PH_R_BITS:  return peer_byte[lnk.bit_idx[2:0]] ^ ($urandom_range(0, 63) == 0);
            default:    return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(bit [1:0] cmd, bit [7:0] txb, bit line);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, line, txb, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lnk.take_request(cmd, txb, line);
        @(negedge clk);
    endtask

    task automatic next_tick(bit [1:0] cmd);
        phase_t ph;
        ph = lnk.phase_for(cmd);
        // peer temper is fixed per operation
        if (lnk.phase == PH_IDLE && ph != PH_IDLE)
            peer_mute = mute_forced ||
                        (lnk.cfg_timeout <= 64 && $urandom_range(0, 99) < 8);
        if (ph != PH_R_BITS)
            peer_byte = 8'($urandom);
        send_req(cmd, 8'($urandom), remote_level(ph));
    endtask

    task automatic program_link(bit [15:0] period, bit [19:0] timeout, bit [7:0] limit);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_BIT_PERIOD;
        cfg_wdata <= 20'(period);
        @(negedge clk);
        cfg_addr  <= CFG_TIMEOUT;
        cfg_wdata <= timeout;
        @(negedge clk);
        cfg_addr  <= CFG_PRE_LIMIT;
        cfg_wdata <= 20'(limit);
        @(negedge clk);
        cfg_we <= 1'b0;
        lnk.cfg_period  = period;
        lnk.cfg_timeout = timeout;
        lnk.cfg_limit   = limit;
    endtask

    // finish the running operation, then let the pipeline empty
    task automatic drain_link();
        while (lnk.phase != PH_IDLE)
            next_tick(CMD_TICK);
        s_axis_tvalid <= 1'b0;
        while (lnk.awaited.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(bit [15:0] period, bit [19:0] timeout, bit [7:0] limit,
                             int n, int wr_pct, int rd_pct, int chat, bit forced);
        int       i;
        int       roll;
        bit [1:0] cmd;
        program_link(period, timeout, limit);
        chatty_pct  = chat;
        mute_forced = forced;
        for (i = 0; i < n; i++)
        begin
            if (lnk.phase == PH_IDLE)
            begin
                roll = $urandom_range(0, 99);
                if (roll < wr_pct)
                    cmd = CMD_WRITE;
                else if (roll < wr_pct + rd_pct)
                    cmd = CMD_READ;
                else if (roll < 95)
                    cmd = CMD_TICK;
                else
                    cmd = CMD_SPARE;
            end
            else
                cmd = ($urandom_range(0, 9) == 0) ? 2'($urandom) : CMD_TICK;
            next_tick(cmd);
        end
        drain_link();
    endtask

    initial
    begin
        int k;
        lnk = new();
        send_idle_pct = 8;
        recv_idle_pct = 56;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero period, one-tick timeout, zero pre-read limit
        program_link(16'd0, 20'd1, 8'd0);
        send_req(CMD_SPARE, 8'hA5, 1'b0);
        send_req(CMD_READ, 8'h00, 1'b1);
        send_req(CMD_TICK, 8'h00, 1'b1);
        send_req(CMD_WRITE, 8'hFF, 1'b0);
        for (k = 0; k < 8; k++)
            send_req(k[0] ? CMD_READ : CMD_WRITE, 8'hFF, 1'b1);
        send_req(CMD_TICK, 8'h00, 1'b0);
        send_req(CMD_TICK, 8'h00, 1'b1);
        send_req(CMD_READ, 8'h00, 1'b1);
        send_req(CMD_WRITE, 8'h00, 1'b1);
        send_req(CMD_SPARE, 8'h00, 1'b1);
        send_req(CMD_TICK, 8'h00, 1'b1);
        drain_link();

        run_phase(16'd2, 20'd12, 8'd1, 160, 45, 30, 30, 1'b0);
        // write-heavy with a chatty peer to fill the ring
        run_phase(16'd1, 20'd6, 8'd255, 220, 70, 5, 75, 1'b0);

        send_idle_pct = 56;
        recv_idle_pct = 8;
        run_phase(16'd5, 20'd30, 8'd4, 110, 40, 40, 35, 1'b0);
        // huge period: keep every operation short with a silent peer
        run_phase(16'd65535, 20'd1, 8'd16, 40, 40, 40, 0, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'd3, 20'd1048575, 8'd2, 110, 40, 40, 30, 1'b0);
        run_phase(16'd8, 20'd10000, 8'd16, 90, 40, 30, 10, 1'b0);

        repeat (8) @(posedge clk);
        if (lnk.errors == 0 && lnk.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
